[rtl/lbpg_pkg.sv]
// Package: shared constants, key and config codes, and controller state type.
package lbpg_pkg;

  localparam int unsigned DEF_MAX_COLS = 64;
  localparam int unsigned DEF_MAX_ROWS = 64;

  localparam int unsigned CELL_W     = 64;
  localparam int unsigned ROW_IDX_W  = 6;
  localparam int unsigned CURSOR_W   = 6;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned SIZE_W     = 7;
  localparam int unsigned GEN_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [KEY_W-1:0] KEY_UP    = 8'h77;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 8'h73;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 8'h61;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 8'h64;
  localparam logic [KEY_W-1:0] KEY_PEN   = 8'h78;

  localparam logic KIND_KEY    = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GENS   = 2'd2;

  localparam logic [SIZE_W-1:0] RST_WIDTH  = 7'd64;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 7'd64;
  localparam logic [GEN_W-1:0]  RST_GENS   = 16'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GEN,
    S_DUMP_RD,
    S_DUMP_LD,
    S_DUMP_WAIT
  } lbpg_state_e;

endpackage

[rtl/lbpg_if.sv]
// Interfaces: key/finish input channel and board row output channel.
interface lbpg_in_if import lbpg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [KEY_W-1:0] key_byte;

  modport source(output valid, kind, key_byte, input ready);
  modport sink(input valid, kind, key_byte, output ready);
endinterface

interface lbpg_out_if import lbpg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ROW_IDX_W-1:0] row_index;
  logic [CELL_W-1:0]    row_cells;
  logic                 last_row;

  modport source(output valid, row_index, row_cells, last_row, input ready);
  modport sink(input valid, row_index, row_cells, last_row, output ready);
endinterface

[rtl/lbpg_grid_mem.sv]
// Board memory: one row per entry, bit write mask, registered read, row valid bits.
module lbpg_grid_mem import lbpg_pkg::*; #(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
  localparam int unsigned AW = $clog2(MAX_ROWS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [AW-1:0]       rd_addr_i,
  output logic [MAX_COLS-1:0] rd_data_o,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  logic [MAX_COLS-1:0] wr_data_i,
  input  logic [MAX_COLS-1:0] wr_mask_i,
  input  logic                clr_en_i,
  input  logic [SIZE_W-1:0]   clr_rows_i
);

  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rd_q;
  logic                rd_vld_q;
  logic [MAX_ROWS-1:0] row_vld_q;

  // an invalid row is written whole: unmasked bits become dead
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        if (!row_vld_q[wr_addr_i] || wr_mask_i[j]) begin
          mem_q[wr_addr_i][j] <= wr_data_i[j] & wr_mask_i[j];
        end
      end
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (clr_en_i) begin
        for (int r = 0; r < MAX_ROWS; r++) begin
          if (SIZE_W'(r) >= clr_rows_i) begin
            row_vld_q[r] <= 1'b0;
          end
        end
      end
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

[rtl/lbpg_row_rule.sv]
// Life rule for one row: bit-sliced neighbor count from the three-row window.
module lbpg_row_rule import lbpg_pkg::*; #(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
  input  logic [MAX_COLS-1:0] up_i,
  input  logic [MAX_COLS-1:0] mid_i,
  input  logic [MAX_COLS-1:0] dn_i,
  input  logic [MAX_COLS-1:0] col_mask_i,
  output logic [MAX_COLS-1:0] next_o
);

  logic [MAX_COLS-1:0] nb [8];
  logic [MAX_COLS-1:0] s0, s1, s2, c0, c1;

  always_comb begin
    nb[0] = (up_i << 1) & col_mask_i;
    nb[1] = up_i;
    nb[2] = up_i >> 1;
    nb[3] = (mid_i << 1) & col_mask_i;
    nb[4] = mid_i >> 1;
    nb[5] = (dn_i << 1) & col_mask_i;
    nb[6] = dn_i;
    nb[7] = dn_i >> 1;
    s0 = '0;
    s1 = '0;
    s2 = '0;
    c0 = '0;
    c1 = '0;
    for (int i = 0; i < 8; i++) begin
      c0 = s0 & nb[i];
      s0 = s0 ^ nb[i];
      c1 = s1 & c0;
      s1 = s1 ^ c0;
      s2 = s2 ^ c1;
    end
    next_o = ((s0 & s1 & ~s2) | (mid_i & ~s0 & s1 & ~s2)) & col_mask_i;
  end

endmodule

[rtl/life_board_pen_and_generations.sv]
// Top level: cursor and pen, generation sequencer and row dump over the board memory.
//
// Input channel in_i carries words of kind and key_byte. A key word (kind 0)
// moves the cursor (w s a d), toggles the pen (x) and, with the pen down,
// marks the cell under the cursor; it produces no output and is taken one
// per cycle while the block is idle.
// A finish word (kind 1) runs generation_count Life generations in place and
// then sends the board on out_o, one word per row in use, top row first,
// last_row set on the final one. A generation streams the rows through the
// registered-read board memory with a three-row window. Each dumped row is
// read from the memory, then loaded into the output register and held there;
// a stalled output word holds until taken. in_i stays not ready until the
// last row has been taken.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) must go in while
// idle; the block itself does not enforce this.
// Reset clears the board through per-row valid bits at once, homes the
// cursor, lifts the pen and sets the size to 64 x 64 with zero generations.
module life_board_pen_and_generations import lbpg_pkg::*; #(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lbpg_in_if.sink               in_i,
  lbpg_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(MAX_ROWS);
  localparam int unsigned SW = $clog2(MAX_ROWS + 2);

  lbpg_state_e state_q, state_d;

  logic [SIZE_W-1:0]   bw_q, bh_q, w_eff, h_eff;
  logic [GEN_W-1:0]    gc_q, gen_q;
  logic [CURSOR_W-1:0] cr_q, cr_d, cc_q, cc_d;
  logic                pen_q, pen_d, key_mark;
  logic                in_fire, out_fire, start;
  logic [SW-1:0]       s_q;
  logic [SIZE_W-1:0]   s7;
  logic                issue, arrive, tail, gen_done, dump_last;
  logic [AW-1:0]       dr_q;
  logic [MAX_COLS-1:0] cm, up_q, mid_q, dn_w, next_row, rd_data;
  logic [CELL_W-1:0]   cells;

  logic                rd_en, wr_en, clr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [MAX_COLS-1:0] wr_data, wr_mask;

  logic                 out_vld_q, out_last_q;
  logic [ROW_IDX_W-1:0] out_row_q;
  logic [CELL_W-1:0]    out_cells_q;

  assign w_eff = (bw_q == '0) ? SIZE_W'(1) :
                 (bw_q > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : bw_q;
  assign h_eff = (bh_q == '0) ? SIZE_W'(1) :
                 (bh_q > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : bh_q;

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      cm[j] = SIZE_W'(j) < w_eff;
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_o.valid && out_o.ready;
  assign start      = in_fire && (in_i.kind == KIND_FINISH);

  // cursor and pen update for a key word
  always_comb begin
    cr_d     = cr_q;
    cc_d     = cc_q;
    pen_d    = pen_q;
    key_mark = 1'b0;
    if (in_fire && in_i.kind == KIND_KEY) begin
      case (in_i.key_byte)
        KEY_UP:    if (cr_q != '0) cr_d = cr_q - CURSOR_W'(1);
        KEY_DOWN:  if (SIZE_W'(cr_q) + SIZE_W'(1) < h_eff) cr_d = cr_q + CURSOR_W'(1);
        KEY_LEFT:  if (cc_q != '0) cc_d = cc_q - CURSOR_W'(1);
        KEY_RIGHT: if (SIZE_W'(cc_q) + SIZE_W'(1) < w_eff) cc_d = cc_q + CURSOR_W'(1);
        KEY_PEN:   pen_d = !pen_q;
        default:   ;
      endcase
      key_mark = pen_d && (SIZE_W'(cr_d) < h_eff) && (SIZE_W'(cc_d) < w_eff);
    end
  end

  // generation sweep: read row s, row s-1 arrives, process and write row s-2
  assign s7       = SIZE_W'(s_q);
  assign issue    = s7 < h_eff;
  assign arrive   = (s7 >= SIZE_W'(1)) && (s7 <= h_eff);
  assign tail     = s7 == h_eff + SIZE_W'(1);
  assign gen_done = tail && (gen_q + GEN_W'(1) == gc_q);
  assign dn_w     = tail ? '0 : (rd_data & cm);
  assign dump_last = SIZE_W'(dr_q) + SIZE_W'(1) == h_eff;

  lbpg_row_rule #(.MAX_COLS(MAX_COLS)) u_rule (
    .up_i       (up_q),
    .mid_i      (mid_q),
    .dn_i       (dn_w),
    .col_mask_i (cm),
    .next_o     (next_row)
  );

  lbpg_grid_mem #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .wr_mask_i  (wr_mask),
    .clr_en_i   (clr_en),
    .clr_rows_i (h_eff)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start) state_d = (gc_q == '0) ? S_DUMP_RD : S_GEN;
      S_GEN: if (gen_done) state_d = S_DUMP_RD;
      S_DUMP_RD: state_d = S_DUMP_LD;
      S_DUMP_LD: state_d = S_DUMP_WAIT;
      S_DUMP_WAIT: if (out_fire) state_d = dump_last ? S_IDLE : S_DUMP_RD;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = dr_q;
    wr_en   = 1'b0;
    wr_addr = cr_d[AW-1:0];
    wr_data = '1;
    wr_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << cc_d;
    clr_en  = 1'b0;
    case (state_q)
      S_IDLE: wr_en = key_mark;
      S_GEN: begin
        rd_en   = issue;
        rd_addr = s_q[AW-1:0];
        wr_en   = s7 >= SIZE_W'(2);
        wr_addr = AW'(s_q - SW'(2));
        wr_data = next_row;
        wr_mask = '1;
        clr_en  = tail;
      end
      S_DUMP_RD: rd_en = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cells = '0;
    cells[MAX_COLS-1:0] = rd_data & cm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      bw_q      <= RST_WIDTH;
      bh_q      <= RST_HEIGHT;
      gc_q      <= RST_GENS;
      cr_q      <= '0;
      cc_q      <= '0;
      pen_q     <= 1'b0;
      s_q       <= '0;
      gen_q     <= '0;
      dr_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cr_q    <= cr_d;
      cc_q    <= cc_d;
      pen_q   <= pen_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  bw_q <= cfg_wdata_i[SIZE_W-1:0];
          CFG_HEIGHT: bh_q <= cfg_wdata_i[SIZE_W-1:0];
          CFG_GENS:   gc_q <= cfg_wdata_i[GEN_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          s_q   <= '0;
          gen_q <= '0;
          dr_q  <= '0;
        end
        S_GEN: begin
          dr_q <= '0;
          if (tail) begin
            s_q   <= '0;
            gen_q <= gen_q + GEN_W'(1);
          end else begin
            s_q <= s_q + SW'(1);
          end
        end
        S_DUMP_LD: out_vld_q <= 1'b1;
        S_DUMP_WAIT: begin
          if (out_fire) begin
            out_vld_q <= 1'b0;
            if (!dump_last) dr_q <= dr_q + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_GEN && arrive) begin
      up_q  <= (s7 == SIZE_W'(1)) ? '0 : mid_q;
      mid_q <= dn_w;
    end
    if (state_q == S_DUMP_LD) begin
      out_row_q   <= ROW_IDX_W'(dr_q);
      out_cells_q <= cells;
      out_last_q  <= dump_last;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.row_index = out_row_q;
  assign out_o.row_cells = out_cells_q;
  assign out_o.last_row  = out_last_q;

  a_busy_no_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input taken while a row word is pending");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && out_o.last_row) |=> in_i.ready)
    else $error("block not idle after the last row");

  a_row_in_board: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (SIZE_W'(out_o.row_index) < h_eff))
    else $error("row index beyond board height");

  a_cols_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.row_cells[MAX_COLS-1:0] & ~cm) == '0))
    else $error("live cell beyond board width");

endmodule

[tb/lbpg_checker.sv]
// Checker for the life board: tracks cursor, pen, sizes and board, predicts row dumps, compares.
module lbpg_checker import lbpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lbpg_in_if                    in_mon,
  lbpg_out_if                   out_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned           errors_o,
  output int unsigned           pending_o,
  output int unsigned           rows_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ROW_IDX_W-1:0] row;
    logic [CELL_W-1:0]    cells;
    logic                 final_row;
  } board_row_t;

  board_row_t        rows_due[$];
  logic [CELL_W-1:0] board[DEF_MAX_ROWS];
  int                cur_row;
  int                cur_col;
  logic              pen;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [GEN_W-1:0]  gens_reg;

  function automatic int size_in_use(input logic [SIZE_W-1:0] v, input int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return int'(v);
  endfunction

  // B3/S23, cells past the edges are dead, everything outside the board is cleared
  function automatic void next_generation(input int cols, input int rows);
    logic [CELL_W-1:0] fresh[DEF_MAX_ROWS];
    int                live;
    for (int r = 0; r < DEF_MAX_ROWS; r++) fresh[r] = '0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < rows &&
                c + dc >= 0 && c + dc < cols) begin
              live += board[r + dr][c + dc];
            end
          end
        end
        fresh[r][c] = (live == 3) || (live == 2 && board[r][c]);
      end
    end
    board = fresh;
  endfunction

  task automatic apply_key(input logic [KEY_W-1:0] key);
    int cols;
    int rows;
    cols = size_in_use(width_reg, DEF_MAX_COLS);
    rows = size_in_use(height_reg, DEF_MAX_ROWS);
    case (key)
      KEY_UP: begin
        if (cur_row > 0) cur_row--;
      end
      KEY_DOWN: begin
        if (cur_row + 1 < rows) cur_row++;
      end
      KEY_LEFT: begin
        if (cur_col > 0) cur_col--;
      end
      KEY_RIGHT: begin
        if (cur_col + 1 < cols) cur_col++;
      end
      KEY_PEN: begin
        pen = !pen;
      end
      default: ;
    endcase
    if (pen && cur_row < rows && cur_col < cols) board[cur_row][cur_col] = 1'b1;
  endtask

  task automatic run_finish();
    int                cols;
    int                rows;
    logic [CELL_W-1:0] keep;
    cols = size_in_use(width_reg, DEF_MAX_COLS);
    rows = size_in_use(height_reg, DEF_MAX_ROWS);
    keep = (cols == CELL_W) ? '1 : ((CELL_W'(1) << cols) - 1);
    for (int g = 0; g < gens_reg; g++) next_generation(cols, rows);
    for (int r = 0; r < rows; r++) begin
      rows_due.push_back('{row: ROW_IDX_W'(r), cells: board[r] & keep,
                           final_row: (r + 1 == rows)});
    end
  endtask

  task automatic check_row();
    board_row_t want;
    if (rows_due.size() == 0) begin
      $error("unexpected row word: row_index %0d row_cells %h last_row %b",
             out_mon.row_index, out_mon.row_cells, out_mon.last_row);
      errors_o++;
    end else begin
      want = rows_due.pop_front();
      if (out_mon.row_index !== want.row) begin
        $error("row_index: expected %0d, got %0d", want.row, out_mon.row_index);
        errors_o++;
      end
      if (out_mon.row_cells !== want.cells) begin
        $error("row_cells: expected %h, got %h", want.cells, out_mon.row_cells);
        errors_o++;
      end
      if (out_mon.last_row !== want.final_row) begin
        $error("last_row: expected %b, got %b", want.final_row, out_mon.last_row);
        errors_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_due.delete();
      for (int r = 0; r < DEF_MAX_ROWS; r++) board[r] = '0;
      cur_row    = 0;
      cur_col    = 0;
      pen        = 1'b0;
      width_reg  = RST_WIDTH;
      height_reg = RST_HEIGHT;
      gens_reg   = RST_GENS;
      errors_o   = 0;
      rows_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WIDTH:  width_reg = cfg_wdata_i[SIZE_W-1:0];
          CFG_HEIGHT: height_reg = cfg_wdata_i[SIZE_W-1:0];
          CFG_GENS:   gens_reg = cfg_wdata_i[GEN_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        rows_o++;
        check_row();
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_FINISH) run_finish();
        else apply_key(in_mon.key_byte);
      end
    end
    pending_o = rows_due.size();
  end

endmodule

[tb/tb_life_board_pen_and_generations.sv]
// Testbench top: clock, reset, key/finish stimulus, register settings, idling and verdict.
module tb_life_board_pen_and_generations;
  timeunit 1ns;
  timeprecision 1ps;
  import lbpg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned QUIET_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned TAIL_CYCLES  = 16;
  localparam int unsigned SEGMENT_LEN  = 36;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned finishes_sent = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors;
  int unsigned pending;
  int unsigned rows_seen;

  lbpg_in_if  in_if();
  lbpg_out_if out_if();

  life_board_pen_and_generations u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  lbpg_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .errors_o   (errors),
    .pending_o  (pending),
    .rows_o     (rows_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL life_board_pen_and_generations");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic kind, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.kind     <= kind;
    in_if.key_byte <= key;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    if (kind == KIND_FINISH) finishes_sent++;
  endtask

  // sampled at the falling edge so the checker has seen the last accepted word
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_board(input logic [CFG_DATA_W-1:0] wd, input logic [CFG_DATA_W-1:0] ht,
                           input logic [CFG_DATA_W-1:0] gens);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_WIDTH;
    cfg_wdata <= wd;
    @(posedge clk_i);
    cfg_idx   <= CFG_HEIGHT;
    cfg_wdata <= ht;
    @(posedge clk_i);
    cfg_idx   <= CFG_GENS;
    cfg_wdata <= gens;
    @(posedge clk_i);
    cfg_idx   <= CFG_SPARE;
    cfg_wdata <= CFG_DATA_W'($urandom);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(9))
      0:       v = '0;
      1:       v = CFG_DATA_W'(1);
      2:       v = CFG_DATA_W'(DEF_MAX_COLS);
      3:       v = CFG_DATA_W'($urandom_range(65, 127));
      4, 5:    v = CFG_DATA_W'($urandom_range(1, 64));
      default: v = CFG_DATA_W'($urandom_range(2, 12));
    endcase
    // bits above the register width are dropped
    if ($urandom_range(1)) v[CFG_DATA_W-1:SIZE_W] = (CFG_DATA_W-SIZE_W)'($urandom);
    return v;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 72) begin
      case (roll % 4)
        0:       return KEY_UP;
        1:       return KEY_DOWN;
        2:       return KEY_LEFT;
        default: return KEY_RIGHT;
      endcase
    end
    if (roll < 84) return KEY_PEN;
    return KEY_W'($urandom);
  endfunction

  // pen walk with a finish every so often, always closed by a finish
  task automatic run_segment(input int unsigned count);
    int unsigned gap;
    gap = $urandom_range(6, 24);
    for (int unsigned i = 1; i < count; i++) begin
      if (gap == 0) begin
        send_word(KIND_FINISH, KEY_W'($urandom));
        gap = $urandom_range(6, 24);
      end else begin
        gap--;
        send_word(KIND_KEY, pick_key());
      end
    end
    send_word(KIND_FINISH, KEY_W'($urandom));
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.kind     = KIND_KEY;
    in_if.key_byte = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_WIDTH;
    cfg_wdata      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 64 x 64, no generations: clamps at the top-left corner, ignored keys still mark
    send_word(KIND_KEY, KEY_PEN);
    send_word(KIND_KEY, KEY_LEFT);
    send_word(KIND_KEY, KEY_UP);
    send_word(KIND_KEY, KEY_RIGHT);
    send_word(KIND_KEY, KEY_DOWN);
    send_word(KIND_KEY, 8'h00);
    send_word(KIND_KEY, 8'hff);
    send_word(KIND_KEY, KEY_RIGHT);
    send_word(KIND_KEY, KEY_PEN);
    send_word(KIND_KEY, KEY_DOWN);
    send_word(KIND_FINISH, 8'hff);

    // shrink under the cursor: down/right stay put, up/left walk back in
    wait_idle();
    set_board(16'd2, 16'd2, 16'd1);
    send_word(KIND_KEY, KEY_PEN);
    send_word(KIND_KEY, KEY_DOWN);
    send_word(KIND_KEY, KEY_RIGHT);
    send_word(KIND_KEY, KEY_UP);
    send_word(KIND_KEY, KEY_LEFT);
    send_word(KIND_FINISH, 8'h00);

    // oversize width: cells outside the old board must have been cleared
    wait_idle();
    set_board(16'd127, 16'd3, 16'd0);
    send_word(KIND_FINISH, 8'h5a);

    // zero size acts as one cell, longest generation run
    wait_idle();
    set_board(16'd0, 16'd0, 16'hffff);
    send_word(KIND_KEY, KEY_UP);
    send_word(KIND_KEY, KEY_LEFT);
    send_word(KIND_FINISH, 8'ha5);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 55;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 55;
        end
        default: begin
          idle_pct  = 24;
          stall_pct = 24;
        end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        wait_idle();
        set_board(pick_size(), pick_size(), CFG_DATA_W'($urandom_range(0, 4)));
        run_segment(SEGMENT_LEN);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d words (%0d finish) across %0d board settings and four idle mixes.",
             words_sent, finishes_sent, settings_used);
    $display("Compared %0d dumped rows, including a 65535-generation run on one cell.",
             rows_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASS life_board_pen_and_generations");
    end else begin
      $display("FAIL life_board_pen_and_generations");
    end
    $finish;
  end

endmodule
